// ----- rtl/core/sssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Shortest path package
// Field widths, the no-edge marker and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned NodeW    = 5;
  localparam int unsigned WeightW  = 14;
  localparam int unsigned DistOutW = 18;

  localparam logic [WeightW-1:0] NoEdge = 14'd10000;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgStartNode = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic init;
    logic relax;
    logic commit;
    logic emit_init;
    logic emit_next;
    logic emit_load;
  } sssp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_acc;
    logic round_done;
    logic found;
    logic at_src;
    logic at_last;
    logic out_free;
  } sssp_sts_t;

endpackage

// ----- rtl/core/sssp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Shortest path controller
// Sequences the matrix clear, edge loading, relaxation rounds and the
// emission of results.
// ----------------------------------------------------------------------------
module sssp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sssp_pkg::sssp_sts_t sts_i,
  output sssp_pkg::sssp_cmd_t cmd_o
);
  import sssp_pkg::*;

  typedef enum logic [2:0] {
    StClear,
    StLoad,
    StInit,
    StRound,
    StSelect,
    StEmitRd,
    StEmitLd
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_done) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        if (sts_i.last_acc) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StRound;
      end
      StRound: begin
        cmd_o.relax = 1'b1;
        if (sts_i.round_done) begin
          state_d = StSelect;
        end
      end
      StSelect: begin
        if (sts_i.found) begin
          cmd_o.commit = 1'b1;
          state_d      = StRound;
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d         = StEmitRd;
        end
      end
      StEmitRd: begin
        if (sts_i.at_src) begin
          if (sts_i.at_last) begin
            state_d = StClear;
          end else begin
            cmd_o.emit_next = 1'b1;
          end
        end else begin
          state_d = StEmitLd;
        end
      end
      StEmitLd: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.at_last) begin
            state_d = StClear;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/sssp_dpath.sv -----
// ----------------------------------------------------------------------------
// Shortest path datapath
// Weight matrix and distance memories, edge load pipeline, the relax and
// select unit, configuration registers and the result register.
// ----------------------------------------------------------------------------
module sssp_dpath #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sssp_pkg::sssp_cmd_t               cmd_i,
  output sssp_pkg::sssp_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [sssp_pkg::NodeW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sssp_pkg::NodeW-1:0]        from_node_i,
  input  logic [sssp_pkg::NodeW-1:0]        to_node_i,
  input  logic [sssp_pkg::WeightW-1:0]      edge_weight_i,
  input  logic                              last_edge_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sssp_pkg::NodeW-1:0]        dest_node_o,
  output logic [sssp_pkg::DistOutW-1:0]     distance_o,
  output logic                              reachable_o,
  output logic                              last_result_o
);
  import sssp_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_NODES);
  localparam int unsigned AddrW  = 2 * IdxW;
  localparam int unsigned WDepth = 1 << AddrW;
  localparam int unsigned CntW   = $clog2(MAX_NODES + 1);
  localparam int unsigned CfgW   = (CntW > NodeW) ? CntW : NodeW;
  localparam int unsigned DistW  = $clog2(MAX_NODES * 10000);

  // Configuration.
  logic [NodeW-1:0] node_count_q, start_node_q;
  logic [CfgW-1:0]  nc_w, sn_w, cnt_sat, src_sat;
  logic [IdxW-1:0]  last_d, src_d;

  // Memories.
  logic [WeightW-1:0] wmem_q [WDepth];
  logic [DistW-1:0]   dmem_q [MAX_NODES];
  logic [WeightW-1:0] w_rd_q, w_wdata;
  logic [AddrW-1:0]   w_raddr, w_waddr;
  logic               w_we;
  logic [DistW-1:0]   d_rd_q;

  // Clearing and loading.
  logic [AddrW-1:0]   clr_q;
  logic [CfgW-1:0]    from_w, to_w;
  logic [IdxW-1:0]    row_in, col_in;
  logic               acc, edge_ok;
  logic               ld_vld_q, ld_we, pw_vld_q;
  logic [AddrW-1:0]   ld_addr_q, pw_addr_q;
  logic [WeightW-1:0] ld_w_q;

  // Search.
  logic [IdxW-1:0]      last_q, src_q, pick_q, k_q, s2_k_q, np_q, prev_last;
  logic [DistW-1:0]     pick_dist_q, nd_q, cand, new_bd;
  logic                 iss_done_q, s2_vld_q, nf_q;
  logic [MAX_NODES-1:0] settled_q, known_q;
  logic                 upd, new_known, better;

  // Results.
  logic                 out_vld_q, out_reach_q, out_last_q;
  logic [NodeW-1:0]     out_dest_q;
  logic [DistW-1:0]     out_dist_q;
  logic [CfgW-1:0]      dest_w;
  logic [31:0]          dist_ext;
  logic                 emit_last;

  always_comb begin
    nc_w    = CfgW'(node_count_q);
    sn_w    = CfgW'(start_node_q);
    cnt_sat = nc_w;
    if (nc_w == '0) begin
      cnt_sat = CfgW'(1);
    end else if (nc_w > CfgW'(MAX_NODES)) begin
      cnt_sat = CfgW'(MAX_NODES);
    end
    src_sat = sn_w;
    if (sn_w == '0) begin
      src_sat = CfgW'(1);
    end else if (sn_w > cnt_sat) begin
      src_sat = cnt_sat;
    end
    last_d = IdxW'(cnt_sat - CfgW'(1));
    src_d  = IdxW'(src_sat - CfgW'(1));
  end

  assign from_w  = CfgW'(from_node_i);
  assign to_w    = CfgW'(to_node_i);
  assign row_in  = IdxW'(from_w - CfgW'(1));
  assign col_in  = IdxW'(to_w - CfgW'(1));
  assign acc     = cmd_i.load & in_valid_i;
  assign edge_ok = (from_w != '0) && (from_w <= CfgW'(MAX_NODES)) &&
                   (to_w != '0) && (to_w <= CfgW'(MAX_NODES)) &&
                   (edge_weight_i < NoEdge);

  // A repeated edge keeps its first weight, so a write issued in the
  // previous cycle to the same entry counts as already stored.
  assign ld_we = ld_vld_q && (w_rd_q >= NoEdge) &&
                 !(pw_vld_q && (pw_addr_q == ld_addr_q));

  assign w_raddr = cmd_i.load ? {row_in, col_in} : {pick_q, k_q};

  always_comb begin
    w_we    = 1'b0;
    w_waddr = ld_addr_q;
    w_wdata = ld_w_q;
    if (cmd_i.clear) begin
      w_we    = 1'b1;
      w_waddr = clr_q;
      w_wdata = NoEdge;
    end else if (ld_we) begin
      w_we = 1'b1;
    end
  end

  always_comb begin
    cand      = pick_dist_q + DistW'(w_rd_q);
    upd       = s2_vld_q && !settled_q[s2_k_q] && (w_rd_q < NoEdge) &&
                (!known_q[s2_k_q] || (cand < d_rd_q));
    new_known = known_q[s2_k_q] | upd;
    new_bd    = upd ? cand : d_rd_q;
    better    = s2_vld_q && !settled_q[s2_k_q] && new_known &&
                (!nf_q || (new_bd < nd_q));
  end

  assign prev_last = last_q - IdxW'(1);
  assign emit_last = (k_q == last_q) || ((last_q == src_q) && (k_q == prev_last));
  assign dest_w    = CfgW'(k_q) + CfgW'(1);

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem_q[w_waddr] <= w_wdata;
    end
    w_rd_q <= wmem_q[w_raddr];
    if (upd) begin
      dmem_q[s2_k_q] <= cand;
    end
    d_rd_q <= dmem_q[k_q];
  end

  always_ff @(posedge clk_i) begin
    ld_addr_q <= {row_in, col_in};
    ld_w_q    <= edge_weight_i;
    pw_addr_q <= ld_addr_q;
    s2_k_q    <= k_q;
    if (cmd_i.init) begin
      last_q      <= last_d;
      src_q       <= src_d;
      pick_q      <= src_d;
      pick_dist_q <= '0;
    end
    if (cmd_i.commit) begin
      pick_q      <= np_q;
      pick_dist_q <= nd_q;
    end
    if (better) begin
      np_q <= s2_k_q;
      nd_q <= new_bd;
    end
    if (cmd_i.emit_load) begin
      out_dest_q  <= dest_w[NodeW-1:0];
      out_dist_q  <= known_q[k_q] ? d_rd_q : DistW'(NoEdge);
      out_reach_q <= known_q[k_q];
      out_last_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeW'(16);
      start_node_q <= NodeW'(1);
      clr_q        <= '0;
      ld_vld_q     <= 1'b0;
      pw_vld_q     <= 1'b0;
      k_q          <= '0;
      iss_done_q   <= 1'b0;
      s2_vld_q     <= 1'b0;
      settled_q    <= '0;
      known_q      <= '0;
      nf_q         <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNodeCount: node_count_q <= cfg_wdata_i;
          CfgStartNode: start_node_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + AddrW'(1);
      end
      ld_vld_q <= acc & edge_ok;
      pw_vld_q <= ld_we;

      s2_vld_q <= cmd_i.relax && !iss_done_q;
      if (cmd_i.relax && !iss_done_q) begin
        if (k_q == last_q) begin
          iss_done_q <= 1'b1;
        end else begin
          k_q <= k_q + IdxW'(1);
        end
      end
      if (upd) begin
        known_q[s2_k_q] <= 1'b1;
      end
      if (better) begin
        nf_q <= 1'b1;
      end
      if (cmd_i.init) begin
        settled_q  <= MAX_NODES'(1) << src_d;
        known_q    <= MAX_NODES'(1) << src_d;
        nf_q       <= 1'b0;
        k_q        <= '0;
        iss_done_q <= 1'b0;
      end else if (cmd_i.commit) begin
        settled_q[np_q] <= 1'b1;
        nf_q            <= 1'b0;
        k_q             <= '0;
        iss_done_q      <= 1'b0;
      end
      if (cmd_i.emit_init) begin
        k_q <= '0;
      end
      if (cmd_i.emit_next) begin
        k_q <= k_q + IdxW'(1);
      end

      if (cmd_i.emit_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = &clr_q;
    sts_o.last_acc   = acc & last_edge_i;
    sts_o.round_done = s2_vld_q && (s2_k_q == last_q);
    sts_o.found      = nf_q;
    sts_o.at_src     = (k_q == src_q);
    sts_o.at_last    = (k_q == last_q);
    sts_o.out_free   = !out_vld_q || !out_stall_i;
  end

  assign dist_ext      = 32'(out_dist_q);
  assign in_stall_o    = ~cmd_i.load;
  assign out_valid_o   = out_vld_q;
  assign dest_node_o   = out_dest_q;
  assign distance_o    = dist_ext[DistOutW-1:0];
  assign reachable_o   = out_reach_q;
  assign last_result_o = out_last_q;

endmodule

// ----- rtl/core/single_source_shortest_paths.sv -----
// ----------------------------------------------------------------------------
// Single-source shortest paths
// Dense shortest-path search over a small directed graph loaded edge by edge.
// ----------------------------------------------------------------------------
// Edges enter on the input channel, one beat per cycle while loading; a
// repeated edge keeps its first weight. The beat with last_edge set closes
// the graph, and the search then runs from start_node over nodes 1 to
// node_count. Each relaxation round sweeps the nodes through the single read
// port of the weight matrix, and there are at most node_count rounds.
// Results then leave in node order, one beat per node other than the
// start; a stalled output holds the beat and pauses the sweep. The input
// stalls from the closing edge until the results are out and the matrix
// has been cleared again.
// After reset, and after every graph, a clearing pass writes the no-edge
// value into all 2**(2*clog2(MAX_NODES)) matrix entries, one a cycle, while
// the input stalls. Configuration is to be written through the plain write
// port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module single_source_shortest_paths #(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [sssp_pkg::NodeW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sssp_pkg::NodeW-1:0]    from_node_i,
  input  logic [sssp_pkg::NodeW-1:0]    to_node_i,
  input  logic [sssp_pkg::WeightW-1:0]  edge_weight_i,
  input  logic                          last_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sssp_pkg::NodeW-1:0]    dest_node_o,
  output logic [sssp_pkg::DistOutW-1:0] distance_o,
  output logic                          reachable_o,
  output logic                          last_result_o
);
  import sssp_pkg::*;

  sssp_cmd_t cmd;
  sssp_sts_t sts;

  sssp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  sssp_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .edge_weight_i (edge_weight_i),
    .last_edge_i   (last_edge_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .dest_node_o   (dest_node_o),
    .distance_o    (distance_o),
    .reachable_o   (reachable_o),
    .last_result_o (last_result_o)
  );

endmodule
